// ===== hw/rtl/xcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// xcfr_pkg
// Types and constants shared by the framed byte receiver with XOR checksum.
// ----------------------------------------------------------------------------
package xcfr_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CfgIdxW = 8;
	localparam int unsigned StatusW = 3;

	localparam logic [ByteW-1:0] START_BYTE = 8'h5C;
	localparam logic [ByteW-1:0] HDR_BYTE1  = 8'h00;
	localparam logic [ByteW-1:0] HDR_BYTE2  = 8'h20;
	localparam logic [ByteW-1:0] QUIRK_CALC = 8'h5C;
	localparam logic [ByteW-1:0] QUIRK_RECV = 8'hC5;
	localparam logic [ByteW-1:0] ACK_BYTE   = 8'h06;
	localparam logic [ByteW-1:0] NAK_BYTE   = 8'h15;

	// reset values of the configuration registers
	localparam logic [ByteW-1:0] MAX_FRAME_LEN_RST   = 8'd200;
	localparam logic [ByteW-1:0] FORWARD_CMD_RST     = 8'h68;
	localparam logic [ByteW-1:0] FORWARD_MIN_LEN_RST = 8'h50;
	localparam logic             CHECKSUM_QUIRK_RST  = 1'b1;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_MAX_FRAME_LEN   = 8'd0;
	localparam logic [CfgIdxW-1:0] REG_FORWARD_CMD     = 8'd1;
	localparam logic [CfgIdxW-1:0] REG_FORWARD_MIN_LEN = 8'd2;
	localparam logic [CfgIdxW-1:0] REG_CHECKSUM_QUIRK  = 8'd3;

	typedef enum logic [StatusW-1:0] {
		ST_IGNORED  = 3'd0,
		ST_COLLECT  = 3'd1,
		ST_GOOD     = 3'd2,
		ST_CHKBAD   = 3'd3,
		ST_HDRBAD   = 3'd4,
		ST_OVERFLOW = 3'd5
	} status_t;

	typedef struct packed {
		logic [ByteW-1:0] max_frame_len;
		logic [ByteW-1:0] forward_cmd;
		logic [ByteW-1:0] forward_min_len;
		logic             checksum_quirk_en;
	} cfg_t;

	typedef struct packed {
		logic             in_frame;
		logic [ByteW-1:0] byte_count;
		logic [ByteW-1:0] second_byte;
		logic [ByteW-1:0] command_field;
		logic [ByteW-1:0] length_field;
		logic [ByteW-1:0] running_xor;
	} frm_state_t;

	typedef struct packed {
		logic [ByteW-1:0] byte_out;
		logic             frame_member;
		status_t          status;
		logic             reply_valid;
		logic [ByteW-1:0] reply_byte;
		logic             forward_frame;
	} result_t;

endpackage

// ===== hw/rtl/xcfr_step.sv =====
// ----------------------------------------------------------------------------
// xcfr_step
// Frame tracking logic for one received byte: next state and result item.
// ----------------------------------------------------------------------------
module xcfr_step (
	input  xcfr_pkg::cfg_t            cfg,
	input  xcfr_pkg::frm_state_t      cur,
	input  logic [xcfr_pkg::ByteW-1:0] byte_in,
	output xcfr_pkg::frm_state_t      nxt,
	output xcfr_pkg::result_t         res
);
	import xcfr_pkg::*;

	logic             starting;
	logic             active;
	logic [ByteW-1:0] idx;
	logic [ByteW-1:0] xor_eff;
	logic [ByteW:0]   n;
	logic [ByteW:0]   end_pos;
	logic             hdr_bad;
	logic             at_end;
	logic             sum_ok;

	always_comb begin
		starting = !cur.in_frame && (byte_in == START_BYTE);
		active   = cur.in_frame || starting;
		idx      = starting ? '0 : cur.byte_count;
		xor_eff  = starting ? '0 : cur.running_xor;
		n        = {1'b0, idx} + {{ByteW{1'b0}}, 1'b1};
		end_pos  = {1'b0, cur.length_field} + (ByteW+1)'(6);
		hdr_bad  = (n == (ByteW+1)'(3)) &&
			((cur.second_byte != HDR_BYTE1) || (byte_in != HDR_BYTE2));
		at_end   = (n >= (ByteW+1)'(6)) && (n == end_pos);
		// a computed 0x5C also takes a received 0xC5 when the quirk is on
		sum_ok   = (xor_eff == byte_in) ||
			(cfg.checksum_quirk_en && (xor_eff == QUIRK_CALC) && (byte_in == QUIRK_RECV));

		nxt = cur;
		nxt.in_frame    = active;
		nxt.byte_count  = idx;
		nxt.running_xor = xor_eff;

		res.byte_out      = byte_in;
		res.frame_member  = 1'b0;
		res.status        = ST_IGNORED;
		res.reply_valid   = 1'b0;
		res.reply_byte    = '0;
		res.forward_frame = 1'b0;

		if (active) begin
			if (n >= {1'b0, cfg.max_frame_len}) begin
				nxt.in_frame = 1'b0;
				res.status   = ST_OVERFLOW;
			end else begin
				nxt.byte_count   = n[ByteW-1:0];
				res.frame_member = 1'b1;
				res.status       = ST_COLLECT;
				if (idx == ByteW'(1)) nxt.second_byte   = byte_in;
				if (idx == ByteW'(3)) nxt.command_field = byte_in;
				if (idx == ByteW'(4)) nxt.length_field  = byte_in;
				priority if (hdr_bad) begin
					nxt.in_frame = 1'b0;
					res.status   = ST_HDRBAD;
				end else if (at_end) begin
					nxt.in_frame    = 1'b0;
					res.reply_valid = 1'b1;
					if (sum_ok) begin
						res.status        = ST_GOOD;
						res.reply_byte    = ACK_BYTE;
						res.forward_frame = (cur.command_field == cfg.forward_cmd) &&
							(cur.length_field >= cfg.forward_min_len);
					end else begin
						res.status     = ST_CHKBAD;
						res.reply_byte = NAK_BYTE;
					end
				end else begin
					nxt.running_xor = (idx >= ByteW'(2)) ? (xor_eff ^ byte_in) : xor_eff;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/xor_checksum_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// xor_checksum_frame_receiver_core
// Framed serial byte receiver with XOR checksum check, ACK/NAK reply and
// forward decision.
// ----------------------------------------------------------------------------
// Usage:
// - input channel (in_valid/in_ready, byte_in) takes one received byte per item
// - output channel (out_valid/out_ready) gives one result item per input item:
//   the byte passed through, frame membership, status, reply byte and the
//   forward flag
// - config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the four
//   registers; always ready, unknown indexes are dropped; write only while idle
// - each result is registered, valid in the cycle after its item is accepted
// - throughput: one item per cycle unless stalled; the frame state and result
//   register are updated in the same cycle from a short compare and XOR path
// - when the receiver stalls, the result register holds and in_ready drops
//   until the held result is taken (taking it frees room the same cycle)
// - reset clears the frame state and the output valid, and loads the register
//   defaults: max length 200, forward command 0x68, forward length 0x50,
//   checksum quirk on
// ----------------------------------------------------------------------------
module xor_checksum_frame_receiver_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [xcfr_pkg::ByteW-1:0]   byte_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [xcfr_pkg::ByteW-1:0]   byte_out,
	output logic                         frame_member,
	output logic [xcfr_pkg::StatusW-1:0] status,
	output logic                         reply_valid,
	output logic [xcfr_pkg::ByteW-1:0]   reply_byte,
	output logic                         forward_frame,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [xcfr_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [xcfr_pkg::ByteW-1:0]   cfg_data
);
	import xcfr_pkg::*;

	cfg_t       cfg_q;
	frm_state_t state_q;
	frm_state_t state_nxt;
	result_t    res_nxt;
	result_t    res_q;
	logic       out_valid_q;
	logic       in_fire;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;

	xcfr_step u_step (
		.cfg     (cfg_q),
		.cur     (state_q),
		.byte_in (byte_in),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_frame_len     <= MAX_FRAME_LEN_RST;
			cfg_q.forward_cmd       <= FORWARD_CMD_RST;
			cfg_q.forward_min_len   <= FORWARD_MIN_LEN_RST;
			cfg_q.checksum_quirk_en <= CHECKSUM_QUIRK_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAX_FRAME_LEN:   cfg_q.max_frame_len     <= cfg_data;
				REG_FORWARD_CMD:     cfg_q.forward_cmd       <= cfg_data;
				REG_FORWARD_MIN_LEN: cfg_q.forward_min_len   <= cfg_data;
				REG_CHECKSUM_QUIRK:  cfg_q.checksum_quirk_en <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				state_q <= state_nxt;
			end
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign byte_out      = res_q.byte_out;
	assign frame_member  = res_q.frame_member;
	assign status        = res_q.status;
	assign reply_valid   = res_q.reply_valid;
	assign reply_byte    = res_q.reply_byte;
	assign forward_frame = res_q.forward_frame;

endmodule

// ===== tb/tb_xor_checksum_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// tb_xor_checksum_frame_receiver_core
// Self-checking bench for the framed byte receiver with XOR checksum. A short
// table of directed bytes runs first: idle bytes, a good frame, a bad
// checksum, a bad header and the 0xC5 checksum exception. Random frames follow
// under several register settings, extremes among them. Every result item is
// compared against its table row or an in-bench model of the frame parser.
// ----------------------------------------------------------------------------
module tb_xor_checksum_frame_receiver_core;
	import xcfr_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 170;
	localparam int SHOW_MAX    = 10;

	typedef struct packed {
		logic [ByteW-1:0] b;
		logic             typed;
		result_t          res;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [ByteW-1:0]     byte_in;
	logic                 out_valid;
	logic                 out_ready;
	logic [ByteW-1:0]     byte_out;
	logic                 frame_member;
	logic [StatusW-1:0]   status;
	logic                 reply_valid;
	logic [ByteW-1:0]     reply_byte;
	logic                 forward_frame;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CfgIdxW-1:0]   cfg_index;
	logic [ByteW-1:0]     cfg_data;

	// model state and register copy
	frm_state_t rx_state;
	cfg_t       rx_regs;
	result_t    pending_results[$];

	// fixed expectation that goes with the byte on the input channel
	logic    cur_typed;
	result_t cur_res;

	logic send_idle_on;
	logic recv_idle_on;
	int   rx_hold_len;
	int   cyc;
	int   fail_cnt;
	int   shown_cnt;
	int   item_cnt;
	int   good_cnt, fwd_cnt, chkbad_cnt, hdrbad_cnt, ovf_cnt, phase_cnt;

	dir_row_t dir_tbl [0:24];

	xor_checksum_frame_receiver_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_in      (byte_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_out     (byte_out),
		.frame_member (frame_member),
		.status       (status),
		.reply_valid  (reply_valid),
		.reply_byte   (reply_byte),
		.forward_frame(forward_frame),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one byte through the frame parser, updates the model state
	function automatic result_t predict_frame_byte(input logic [ByteW-1:0] b);
		result_t     r;
		int unsigned idx;
		int unsigned n;
		logic        ok;
		r = '0;
		r.byte_out = b;
		r.status = ST_IGNORED;
		if (!rx_state.in_frame && b == START_BYTE) begin
			rx_state.in_frame = 1'b1;
			rx_state.byte_count = '0;
			rx_state.running_xor = '0;
		end
		if (rx_state.in_frame) begin
			idx = rx_state.byte_count;
			n = idx + 1;
			if (n >= rx_regs.max_frame_len) begin
				rx_state.in_frame = 1'b0;
				r.status = ST_OVERFLOW;
			end else begin
				rx_state.byte_count = ByteW'(n);
				r.frame_member = 1'b1;
				r.status = ST_COLLECT;
				if (idx == 1) rx_state.second_byte = b;
				if (idx == 3) rx_state.command_field = b;
				if (idx == 4) rx_state.length_field = b;
				if (n == 3 && (rx_state.second_byte != HDR_BYTE1 || b != HDR_BYTE2)) begin
					rx_state.in_frame = 1'b0;
					r.status = ST_HDRBAD;
				end else if (n >= 6 && n == rx_state.length_field + 32'd6) begin
					ok = (rx_state.running_xor == b) ||
						(rx_regs.checksum_quirk_en && rx_state.running_xor == QUIRK_CALC &&
						b == QUIRK_RECV);
					rx_state.in_frame = 1'b0;
					r.reply_valid = 1'b1;
					if (ok) begin
						r.status = ST_GOOD;
						r.reply_byte = ACK_BYTE;
						r.forward_frame = (rx_state.command_field == rx_regs.forward_cmd &&
							rx_state.length_field >= rx_regs.forward_min_len);
					end else begin
						r.status = ST_CHKBAD;
						r.reply_byte = NAK_BYTE;
					end
				end else if (idx >= 2) begin
					rx_state.running_xor = rx_state.running_xor ^ b;
				end
			end
		end
		return r;
	endfunction

	function automatic dir_row_t dir_row(input logic [ByteW-1:0] b, input logic typed,
		input status_t st);
		dir_row_t r;
		r.b = b;
		r.typed = typed;
		r.res.byte_out = b;
		r.res.frame_member = (st != ST_IGNORED && st != ST_OVERFLOW);
		r.res.status = st;
		r.res.reply_valid = (st == ST_GOOD || st == ST_CHKBAD);
		r.res.reply_byte = (st == ST_GOOD) ? ACK_BYTE : (st == ST_CHKBAD) ? NAK_BYTE : 8'h00;
		r.res.forward_frame = 1'b0;
		return r;
	endfunction

	function automatic int pick_gap(input logic on);
		return on ? $urandom_range(0, 14) : 0;
	endfunction

	// accepted items feed the model, accepted results are checked in order
	always @(posedge clk) begin
		result_t pred;
		result_t e;
		logic    bad;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				pred = predict_frame_byte(byte_in);
				pending_results.push_back(cur_typed ? cur_res : pred);
				item_cnt++;
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					fail_cnt++;
					if (shown_cnt < SHOW_MAX) begin
						shown_cnt++;
						$display("[%0d] unexpected result byte_out=%02h status=%0d", cyc,
							byte_out, status);
					end
				end else begin
					e = pending_results.pop_front();
					bad = (byte_out !== e.byte_out) || (frame_member !== e.frame_member) ||
						(status !== e.status) || (reply_valid !== e.reply_valid) ||
						(reply_byte !== e.reply_byte) || (forward_frame !== e.forward_frame);
					if (bad) begin
						fail_cnt++;
						if (shown_cnt < SHOW_MAX) begin
							shown_cnt++;
							$display("[%0d] exp: b=%02h m=%0b s=%0d rv=%0b rb=%02h f=%0b",
								cyc, e.byte_out, e.frame_member, e.status, e.reply_valid,
								e.reply_byte, e.forward_frame);
							$display("[%0d] act: b=%02h m=%0b s=%0d rv=%0b rb=%02h f=%0b",
								cyc, byte_out, frame_member, status, reply_valid,
								reply_byte, forward_frame);
						end
					end
					case (e.status)
						ST_GOOD:     good_cnt++;
						ST_CHKBAD:   chkbad_cnt++;
						ST_HDRBAD:   hdrbad_cnt++;
						ST_OVERFLOW: ovf_cnt++;
						default: ;
					endcase
					if (e.forward_frame) fwd_cnt++;
				end
			end
		end
	end

	// result side: random stalls per item, plus a long hold-off on request
	initial begin
		int n;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (rx_hold_len != 0) begin
				n = rx_hold_len;
				rx_hold_len = 0;
				out_ready = 1'b0;
				repeat (n) @(negedge clk);
			end
			n = pick_gap(recv_idle_on);
			if (n != 0) begin
				out_ready = 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cyc,
			pending_results.size());
		$display("Test completed with failures");
		$finish;
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_byte(input logic [ByteW-1:0] b, input logic typed, input result_t res);
		int gap;
		gap = pick_gap(send_idle_on);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_in = b;
		cur_typed = typed;
		cur_res = res;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic wait_results_drained();
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MAX_FRAME_LEN:   rx_regs.max_frame_len = val;
			REG_FORWARD_CMD:     rx_regs.forward_cmd = val;
			REG_FORWARD_MIN_LEN: rx_regs.forward_min_len = val;
			REG_CHECKSUM_QUIRK:  rx_regs.checksum_quirk_en = val[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [ByteW-1:0] max_len, input logic [ByteW-1:0] cmd,
		input logic [ByteW-1:0] min_len, input logic quirk);
		write_reg(REG_MAX_FRAME_LEN, max_len);
		write_reg(REG_FORWARD_CMD, cmd);
		write_reg(REG_FORWARD_MIN_LEN, min_len);
		// upper data bits must be dropped by the 1-bit register
		write_reg(REG_CHECKSUM_QUIRK, {(ByteW-1)'($urandom_range(0, 127)), quirk});
		// unknown index, must leave everything alone
		write_reg(CfgIdxW'($urandom_range(4, 255)), ByteW'($urandom));
		cfg_valid = 1'b0;
		phase_cnt++;
	endtask

	// mostly well-formed frames, some noise, broken headers, quirk and bad checksums,
	// truncated frames; returns how many bytes were sent
	task automatic send_random_frame(output int nsent);
		logic [ByteW-1:0] fb[$];
		logic [ByteW-1:0] x;
		logic [ByteW-1:0] cmd;
		int               len;
		int               kind;
		kind = $urandom_range(0, 99);
		nsent = 0;
		if (kind < 10) begin
			repeat ($urandom_range(1, 4)) fb.push_back(ByteW'($urandom));
		end else begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
			cmd = $urandom_range(0, 1) ? rx_regs.forward_cmd : ByteW'($urandom);
			fb = {START_BYTE, HDR_BYTE1, HDR_BYTE2, cmd, ByteW'(len)};
			if (kind < 18) fb[1 + $urandom_range(0, 1)] ^= ByteW'($urandom_range(1, 255));
			repeat (len) fb.push_back(ByteW'($urandom));
			x = '0;
			for (int i = 2; i < fb.size(); i++) x ^= fb[i];
			// steer the checksum to 0x5C through the last data byte
			if (kind >= 18 && kind < 26 && len != 0) begin
				fb[fb.size() - 1] ^= x ^ QUIRK_CALC;
				x = QUIRK_CALC;
			end
			if (kind >= 18 && kind < 26) begin
				fb.push_back(QUIRK_RECV);
			end else if (kind >= 26 && kind < 36) begin
				fb.push_back(x ^ ByteW'($urandom_range(1, 255)));
			end else if (kind >= 36 && kind < 42) begin
				repeat ($urandom_range(0, fb.size() - 1)) void'(fb.pop_back());
			end else begin
				fb.push_back(x);
			end
		end
		nsent = fb.size();
		foreach (fb[i]) send_byte(fb[i], 1'b0, '0);
	endtask

	initial begin
		int phase_items;
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_in = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cur_typed = 1'b0;
		cur_res = '0;
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		rx_hold_len = 0;
		fail_cnt = 0;
		shown_cnt = 0;
		item_cnt = 0;
		good_cnt = 0;
		fwd_cnt = 0;
		chkbad_cnt = 0;
		hdrbad_cnt = 0;
		ovf_cnt = 0;
		phase_cnt = 0;
		rx_state = '0;
		rx_regs.max_frame_len = MAX_FRAME_LEN_RST;
		rx_regs.forward_cmd = FORWARD_CMD_RST;
		rx_regs.forward_min_len = FORWARD_MIN_LEN_RST;
		rx_regs.checksum_quirk_en = CHECKSUM_QUIRK_RST;

		dir_tbl = '{
			// idle bytes
			dir_row(8'h00, 1'b1, ST_IGNORED),
			dir_row(8'hFF, 1'b1, ST_IGNORED),
			// good frame, empty payload, checksum 0x20^0x68
			dir_row(8'h5C, 1'b1, ST_COLLECT),
			dir_row(8'h00, 1'b1, ST_COLLECT),
			dir_row(8'h20, 1'b1, ST_COLLECT),
			dir_row(8'h68, 1'b1, ST_COLLECT),
			dir_row(8'h00, 1'b1, ST_COLLECT),
			dir_row(8'h48, 1'b1, ST_GOOD),
			// same frame with a wrong checksum
			dir_row(8'h5C, 1'b1, ST_COLLECT),
			dir_row(8'h00, 1'b1, ST_COLLECT),
			dir_row(8'h20, 1'b1, ST_COLLECT),
			dir_row(8'h68, 1'b1, ST_COLLECT),
			dir_row(8'h00, 1'b1, ST_COLLECT),
			dir_row(8'h00, 1'b1, ST_CHKBAD),
			// bad first header byte
			dir_row(8'h5C, 1'b1, ST_COLLECT),
			dir_row(8'h01, 1'b1, ST_COLLECT),
			dir_row(8'h20, 1'b1, ST_HDRBAD),
			// computed 0x5C, received 0xC5
			dir_row(8'h5C, 1'b1, ST_COLLECT),
			dir_row(8'h00, 1'b1, ST_COLLECT),
			dir_row(8'h20, 1'b1, ST_COLLECT),
			dir_row(8'h7C, 1'b1, ST_COLLECT),
			dir_row(8'h00, 1'b1, ST_COLLECT),
			dir_row(8'hC5, 1'b1, ST_GOOD),
			// start byte as second byte, left to the model
			dir_row(8'h5C, 1'b0, ST_COLLECT),
			dir_row(8'h5C, 1'b0, ST_COLLECT)
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tbl[i]) send_byte(dir_tbl[i].b, dir_tbl[i].typed, dir_tbl[i].res);
		wait_results_drained();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: program_regs(8'd7, 8'h00, 8'h00, 1'b0);
				1: program_regs(8'd255, 8'hFF, 8'hFF, 1'b1);
				2: program_regs(MAX_FRAME_LEN_RST, FORWARD_CMD_RST, FORWARD_MIN_LEN_RST,
					CHECKSUM_QUIRK_RST);
				default: program_regs(ByteW'($urandom_range(7, 40)), ByteW'($urandom),
					ByteW'($urandom_range(0, 12)), 1'($urandom_range(0, 1)));
			endcase
			send_idle_on = p[0];
			recv_idle_on = p[1];
			// fast sender against a stalled receiver fills the block
			if (p == 0) rx_hold_len = 60;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				send_random_frame(n);
				phase_items += n;
			end
			wait_results_drained();
		end

		repeat (4) @(posedge clk);
		if (pending_results.size() != 0) begin
			fail_cnt += pending_results.size();
			$display("%0d expected results never arrived", pending_results.size());
		end
		$display("%0d items over %0d register settings: %0d good (%0d fwd), %0d bad sum,",
			item_cnt, phase_cnt + 1, good_cnt, fwd_cnt, chkbad_cnt);
		$display("%0d bad header, %0d overflow; %0d failures", hdrbad_cnt, ovf_cnt, fail_cnt);
		if (fail_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
